// ===== rtl/lfubct_pkg.sv =====
// lfubct_pkg: shared types, codes and defaults for the lfu block cache tag logic
// no dependencies; used by the channel interfaces and every rtl module
`default_nettype none

package lfubct_pkg;

  // default configuration of the cache
  localparam int WAYS_DEF       = 8;
  localparam int ADDR_BITS_DEF  = 48;
  localparam int COUNT_BITS_DEF = 32;

  // fixed field widths on the channels
  localparam int IN_ADDR_BITS = 48;
  localparam int WAY_BITS     = 3;
  localparam int STATUS_BITS  = 2;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_HIT    = 2'd0,
    ST_FILLED = 2'd1,
    ST_FAILED = 2'd2
  } status_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/lfubct_if.sv =====
// lfubct_in_if / lfubct_out_if: valid/ready channels for request and result words
// depends on lfubct_pkg for field widths
`default_nettype none

interface lfubct_in_if;
  import lfubct_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IN_ADDR_BITS-1:0] block_address;
  logic                    fill_ok;

  modport source (output valid, block_address, fill_ok, input ready);
  modport sink   (input valid, block_address, fill_ok, output ready);
endinterface

interface lfubct_out_if;
  import lfubct_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [WAY_BITS-1:0]    way;
  logic                   hit;
  logic [STATUS_BITS-1:0] status;

  modport source (output valid, way, hit, status, input ready);
  modport sink   (input valid, way, hit, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/lfubct_front.sv =====
// lfubct_front: accepts request words, trims the address to a tag, queues them
// depends on lfubct_pkg and lfubct_in_if
`default_nettype none

module lfubct_front #(
  parameter int ADDR_BITS = lfubct_pkg::ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  lfubct_in_if.sink                 in_ch,
  output logic                      q_valid,
  input  wire logic                 q_pop,
  output logic [ADDR_BITS-1:0]      q_tag,
  output logic                      q_fill_ok
);
  import lfubct_pkg::*;

  localparam int DEPTH = 2;

  logic [ADDR_BITS-1:0] q_tag_r [DEPTH];
  logic                 q_ok_r  [DEPTH];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           count_r, count_nxt;
  logic                 push;
  logic [ADDR_BITS+IN_ADDR_BITS-1:0] addr_ext;
  logic [ADDR_BITS-1:0] in_tag;

  // zero-extend then keep the low tag bits
  assign addr_ext = {{ADDR_BITS{1'b0}}, in_ch.block_address};
  assign in_tag   = addr_ext[ADDR_BITS-1:0];

  assign in_ch.ready = (count_r != 2'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  assign q_valid   = (count_r != 2'd0);
  assign q_tag     = q_tag_r[rd_ptr_r];
  assign q_fill_ok = q_ok_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_tag_r[wr_ptr_r] <= in_tag;
      q_ok_r[wr_ptr_r]  <= in_ch.fill_ok;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfubct_back.sv =====
// lfubct_back: scans the ways one per cycle for a hit and the lfu victim, updates
// tag/usage storage and holds the result word; depends on lfubct_pkg, lfubct_out_if
`default_nettype none

module lfubct_back #(
  parameter int WAYS       = lfubct_pkg::WAYS_DEF,
  parameter int ADDR_BITS  = lfubct_pkg::ADDR_BITS_DEF,
  parameter int COUNT_BITS = lfubct_pkg::COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire logic [ADDR_BITS-1:0] q_tag,
  input  wire logic                 q_fill_ok,
  lfubct_out_if.source              out_ch
);
  import lfubct_pkg::*;

  localparam int IDX_W = $clog2(WAYS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(WAYS - 1);

  // tag and usage storage, one shared write port and one read port
  logic [ADDR_BITS-1:0]  tag_mem [WAYS];
  logic [COUNT_BITS-1:0] use_mem [WAYS];
  logic [ADDR_BITS-1:0]  rd_tag_r;
  logic [COUNT_BITS-1:0] rd_use_r;
  logic                  tag_we, use_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [ADDR_BITS-1:0]  wr_tag;
  logic [COUNT_BITS-1:0] wr_use;

  logic [WAYS-1:0] valid_r, valid_nxt;

  back_state_t state_r, state_nxt;

  // current request
  logic [ADDR_BITS-1:0] req_tag_r, req_tag_nxt;
  logic                 req_ok_r, req_ok_nxt;

  // scan pipeline: issue address, then evaluate the registered read in the next cycle
  logic [IDX_W:0]   rd_cnt_r, rd_cnt_nxt;
  logic [IDX_W-1:0] rd_addr;
  logic             ev_v_r, ev_v_nxt;
  logic [IDX_W-1:0] ev_idx_r, ev_idx_nxt;

  // scan results
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [COUNT_BITS-1:0] hit_use_r, hit_use_nxt;
  logic                  have_min_r, have_min_nxt;
  logic [IDX_W-1:0]      min_idx_r, min_idx_nxt;
  logic [COUNT_BITS-1:0] min_use_r, min_use_nxt;

  // result register
  logic                   out_v_r, out_v_nxt;
  logic [WAY_BITS-1:0]    out_way_r, out_way_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic [STATUS_BITS-1:0] out_st_r, out_st_nxt;

  logic                  ev_valid;
  logic [COUNT_BITS-1:0] ev_use;
  logic                  ev_hit;
  logic [IDX_W-1:0]      sel_idx;
  logic [WAY_BITS+IDX_W-1:0] sel_ext;
  logic                  out_free;

  assign out_ch.valid  = out_v_r;
  assign out_ch.way    = out_way_r;
  assign out_ch.hit    = out_hit_r;
  assign out_ch.status = out_st_r;

  assign rd_addr  = rd_cnt_r[IDX_W-1:0];
  assign ev_valid = valid_r[ev_idx_r];
  // an invalid way counts as never used
  assign ev_use   = ev_valid ? rd_use_r : '0;
  assign ev_hit   = ev_valid && (rd_tag_r == req_tag_r);
  assign sel_idx  = found_r ? hit_idx_r : min_idx_r;
  assign sel_ext  = {{WAY_BITS{1'b0}}, sel_idx};
  assign out_free = !out_v_r || out_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    req_tag_nxt  = req_tag_r;
    req_ok_nxt   = req_ok_r;
    rd_cnt_nxt   = rd_cnt_r;
    ev_v_nxt     = 1'b0;
    ev_idx_nxt   = ev_idx_r;
    found_nxt    = found_r;
    hit_idx_nxt  = hit_idx_r;
    hit_use_nxt  = hit_use_r;
    have_min_nxt = have_min_r;
    min_idx_nxt  = min_idx_r;
    min_use_nxt  = min_use_r;
    valid_nxt    = valid_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_way_nxt  = out_way_r;
    out_hit_nxt  = out_hit_r;
    out_st_nxt   = out_st_r;
    q_pop        = 1'b0;
    tag_we       = 1'b0;
    use_we       = 1'b0;
    wr_addr      = sel_idx;
    wr_tag       = req_tag_r;
    wr_use       = COUNT_BITS'(1);

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          req_tag_nxt  = q_tag;
          req_ok_nxt   = q_fill_ok;
          rd_cnt_nxt   = '0;
          found_nxt    = 1'b0;
          have_min_nxt = 1'b0;
          state_nxt    = BK_SCAN;
        end
      end

      BK_SCAN: begin
        if (rd_cnt_r < (IDX_W+1)'(WAYS)) begin
          ev_v_nxt   = 1'b1;
          ev_idx_nxt = rd_addr;
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (ev_v_r) begin
          // first valid match wins
          if (ev_hit && !found_r) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = ev_idx_r;
            hit_use_nxt = rd_use_r;
          end
          // strict compare keeps the lowest index on ties
          if (!have_min_r || (ev_use < min_use_r)) begin
            have_min_nxt = 1'b1;
            min_idx_nxt  = ev_idx_r;
            min_use_nxt  = ev_use;
          end
          if (ev_idx_r == LAST_IDX) begin
            state_nxt = BK_DONE;
          end
        end
      end

      BK_DONE: begin
        if (out_free) begin
          out_v_nxt   = 1'b1;
          out_way_nxt = sel_ext[WAY_BITS-1:0];
          out_hit_nxt = found_r;
          if (found_r) begin
            use_we     = 1'b1;
            wr_use     = (hit_use_r == COUNT_MAX) ? hit_use_r : hit_use_r + 1'b1;
            out_st_nxt = ST_HIT;
          end else if (req_ok_r) begin
            tag_we             = 1'b1;
            use_we             = 1'b1;
            valid_nxt[sel_idx] = 1'b1;
            out_st_nxt         = ST_FILLED;
          end else begin
            out_st_nxt = ST_FAILED;
          end
          state_nxt = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= '0;
      ev_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      ev_v_r  <= ev_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_tag_r  <= req_tag_nxt;
    req_ok_r   <= req_ok_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    ev_idx_r   <= ev_idx_nxt;
    found_r    <= found_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_use_r  <= hit_use_nxt;
    have_min_r <= have_min_nxt;
    min_idx_r  <= min_idx_nxt;
    min_use_r  <= min_use_nxt;
    out_way_r  <= out_way_nxt;
    out_hit_r  <= out_hit_nxt;
    out_st_r   <= out_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (use_we) begin
      use_mem[wr_addr] <= wr_use;
    end
    rd_tag_r <= tag_mem[rd_addr];
    rd_use_r <= use_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/lfu_block_cache_tags.sv =====
// lfu_block_cache_tags: top level of the lfu block cache tag and replacement logic
// depends on lfubct_pkg, lfubct_if, lfubct_front and lfubct_back
`default_nettype none

// Tag lookup and least-frequently-used replacement for a fully associative
// block cache of WAYS ways. Each request word carries a block address and a
// fill_ok flag; each produces exactly one result word with the way, a hit flag
// and a status (hit, miss filled, miss fill failed). A hit bumps the way's
// usage count, saturating at all ones; a miss picks the lowest-index way with
// the smallest usage count, and on a good fill loads it with the new tag and a
// count of one. A failed fill changes nothing. Requests enter a two-word queue
// in the front end, so up to two can be taken while the back end is busy or a
// result waits. The back end handles one request at a time: it reads the tag
// and usage memory one way per cycle through its single read port. No
// clearing pass is needed after reset: per-way valid bits reset at once and
// an invalid way counts as unused.
module lfu_block_cache_tags #(
  parameter int WAYS       = lfubct_pkg::WAYS_DEF,
  parameter int ADDR_BITS  = lfubct_pkg::ADDR_BITS_DEF,
  parameter int COUNT_BITS = lfubct_pkg::COUNT_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  lfubct_in_if.sink    in_ch,
  lfubct_out_if.source out_ch
);
  import lfubct_pkg::*;

  // queue head between front and back
  logic                 q_valid;
  logic                 q_pop;
  logic [ADDR_BITS-1:0] q_tag;
  logic                 q_fill_ok;

  // front end: accepts request words and buffers them
  lfubct_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_tag     (q_tag),
    .q_fill_ok (q_fill_ok)
  );

  // back end: way scan, victim choice, storage update and result word
  lfubct_back #(
    .WAYS       (WAYS),
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_tag     (q_tag),
    .q_fill_ok (q_fill_ok),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench for lfu_block_cache_tags: a scoreboard class tracks tags, valid bits and usage counts
// depends on lfubct_pkg, the lfubct_in_if / lfubct_out_if channels and the rtl top level

// one expected lookup outcome, as carried by a result word
typedef struct packed {
  logic [lfubct_pkg::WAY_BITS-1:0] way;
  logic                            hit;
  lfubct_pkg::status_t             status;
} lookup_result_t;

class lfu_tag_tracker;
  logic [lfubct_pkg::ADDR_BITS_DEF-1:0]  tag_mem   [lfubct_pkg::WAYS_DEF];
  bit                                    valid_mem [lfubct_pkg::WAYS_DEF];
  logic [lfubct_pkg::COUNT_BITS_DEF-1:0] usage_mem [lfubct_pkg::WAYS_DEF];
  lookup_result_t                        pending_results[$];
  int                                    failures;

  function new();
    for (int i = 0; i < lfubct_pkg::WAYS_DEF; i++) begin
      tag_mem[i]   = '0;
      valid_mem[i] = 1'b0;
      usage_mem[i] = '0;
    end
    failures = 0;
  endfunction

  // lookup plus lfu update for one accepted request word
  function void note_request(logic [lfubct_pkg::IN_ADDR_BITS-1:0] addr, logic fill_ok);
    lookup_result_t                       r;
    logic [lfubct_pkg::ADDR_BITS_DEF-1:0] tag;
    int                                   w;
    tag = addr[lfubct_pkg::ADDR_BITS_DEF-1:0];
    w = -1;
    for (int i = 0; i < lfubct_pkg::WAYS_DEF; i++)
      if (w < 0 && valid_mem[i] && tag_mem[i] == tag) w = i;
    if (w >= 0) begin
      if (usage_mem[w] != {lfubct_pkg::COUNT_BITS_DEF{1'b1}}) usage_mem[w] = usage_mem[w] + 1'b1;
      r.hit    = 1'b1;
      r.status = lfubct_pkg::ST_HIT;
    end else begin
      // lowest index wins among equal smallest counts
      w = 0;
      for (int i = 1; i < lfubct_pkg::WAYS_DEF; i++)
        if (usage_mem[i] < usage_mem[w]) w = i;
      r.hit = 1'b0;
      if (fill_ok) begin
        tag_mem[w]   = tag;
        valid_mem[w] = 1'b1;
        usage_mem[w] = lfubct_pkg::COUNT_BITS_DEF'(1);
        r.status     = lfubct_pkg::ST_FILLED;
      end else begin
        r.status = lfubct_pkg::ST_FAILED;
      end
    end
    r.way = w[lfubct_pkg::WAY_BITS-1:0];
    pending_results.push_back(r);
  endfunction

  function void check_result(logic [lfubct_pkg::WAY_BITS-1:0] way, logic hit,
                             logic [lfubct_pkg::STATUS_BITS-1:0] status);
    lookup_result_t e;
    if (pending_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("error: result word way %0d hit %0d status %0d with no request pending",
                 way, hit, status);
      return;
    end
    e = pending_results.pop_front();
    if (way !== e.way || hit !== e.hit || status !== e.status) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: way exp %0d got %0d, hit exp %0d got %0d, status exp %0d got %0d",
                 e.way, way, e.hit, hit, e.status, status);
    end
  endfunction
endclass

module testbench;
  import lfubct_pkg::*;

  localparam int RANDOM_WORDS = 600;     // random request words after the directed part
  localparam int QUIET_TAIL   = 80;      // last words run with no idling on either side
  localparam int STALL_AFTER  = 250;     // accepted words before the long receiver hold-off
  localparam int STALL_CYCLES = 400;     // length of that hold-off
  localparam int DRAIN_CYCLES = 40;      // drain wait after the last result
  localparam int CYCLE_LIMIT  = 300000;  // hard stop, far above the slowest correct run

  logic clk = 1'b0;
  logic rst_n;

  lfubct_in_if  req_ch ();
  lfubct_out_if res_ch ();

  lfu_block_cache_tags uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  always #4 clk = ~clk;

  lfu_tag_tracker tracker = new();

  int unsigned cycle_count       = 0;
  int unsigned accepted_requests = 0;
  bit          quiet_tail        = 1'b0;
  int          send_gap_percent  = 20;

  // working set of block addresses, so that hits and evictions are frequent
  logic [IN_ADDR_BITS-1:0] hot_set [16];
  int                      hot_size;

  // both channels sampled at the edge, before any nonblocking update lands
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        tracker.note_request(req_ch.block_address, req_ch.fill_ok);
        accepted_requests <= accepted_requests + 1;
      end
      if (res_ch.valid && res_ch.ready)
        tracker.check_result(res_ch.way, res_ch.hit, res_ch.status);
    end
  end

  // hard stop if the block hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // offer one request word, optionally after an idle burst; returns once accepted
  task automatic offer_request(input logic [IN_ADDR_BITS-1:0] addr, input logic fill_ok);
    if (!quiet_tail && $urandom_range(0, 99) < send_gap_percent) begin
      req_ch.valid         <= 1'b0;
      // junk payload while idle, must be ignored
      req_ch.block_address <= IN_ADDR_BITS'({$urandom, $urandom});
      req_ch.fill_ok       <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.block_address <= addr;
    req_ch.fill_ok       <= fill_ok;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic logic [IN_ADDR_BITS-1:0] random_address();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[IN_ADDR_BITS-1:0];
  endfunction

  // mostly working-set addresses, plus fresh ones, extremes and one-bit neighbors
  function automatic logic [IN_ADDR_BITS-1:0] pick_address();
    int                      sel;
    logic [IN_ADDR_BITS-1:0] one_bit;
    sel     = $urandom_range(0, 99);
    one_bit = {{(IN_ADDR_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, IN_ADDR_BITS - 1);
    if (sel < 70) return hot_set[$urandom_range(0, hot_size - 1)];
    if (sel < 84) return random_address();
    if (sel < 87) return '0;
    if (sel < 90) return '1;
    if (sel < 93) return one_bit;
    return hot_set[$urandom_range(0, hot_size - 1)] ^ one_bit;
  endfunction

  // reshuffle part of the working set and the sender idling rate
  task automatic new_segment();
    hot_size = $urandom_range(3, 14);
    for (int i = 0; i < 16; i++)
      if ($urandom_range(0, 2) == 0)
        hot_set[i] = ($urandom_range(0, 3) == 0) ? IN_ADDR_BITS'($urandom_range(0, 15))
                                                 : random_address();
    case ($urandom_range(0, 2))
      0: begin
        send_gap_percent = 0;
      end
      1: begin
        send_gap_percent = 15;
      end
      default: begin
        send_gap_percent = 50;
      end
    endcase
  endtask

  // receiver: random hold-off bursts, one long hold-off, then always ready at the end
  initial begin
    int  stall_percent;
    bit  long_stall_done;
    stall_percent   = 20;
    long_stall_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cycle_count % 128 == 0) stall_percent = $urandom_range(0, 2) * 25;
      if (!long_stall_done && accepted_requests >= STALL_AFTER) begin
        // long hold-off so the front end queue fills and input stalls
        long_stall_done = 1'b1;
        res_ch.ready <= 1'b0;
        for (int n = 0; n < STALL_CYCLES; n++) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_percent) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // sender: reset, directed words, random words, then drain
  initial begin
    logic [IN_ADDR_BITS-1:0] dir_addr [20];
    logic                    dir_ok   [20];

    rst_n                <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.block_address <= '0;
    req_ch.fill_ok       <= 1'b0;
    for (int i = 0; i < 16; i++) hot_set[i] = random_address();
    hot_size = 8;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // block 0 against cleared ways: failed fill, then fill, then hit
    dir_addr[0]  = '0;                  dir_ok[0]  = 1'b0;
    dir_addr[1]  = '0;                  dir_ok[1]  = 1'b1;
    dir_addr[2]  = '0;                  dir_ok[2]  = 1'b0;
    // all-ones address
    dir_addr[3]  = '1;                  dir_ok[3]  = 1'b0;
    dir_addr[4]  = '1;                  dir_ok[4]  = 1'b1;
    dir_addr[5]  = '1;                  dir_ok[5]  = 1'b1;
    // fill the remaining ways, ties resolved to the lowest index
    dir_addr[6]  = 48'h0000_0000_0001;  dir_ok[6]  = 1'b1;
    dir_addr[7]  = 48'h8000_0000_0000;  dir_ok[7]  = 1'b1;
    dir_addr[8]  = 48'h5555_5555_5555;  dir_ok[8]  = 1'b1;
    dir_addr[9]  = 48'haaaa_aaaa_aaaa;  dir_ok[9]  = 1'b1;
    dir_addr[10] = 48'h0000_ffff_0000;  dir_ok[10] = 1'b1;
    dir_addr[11] = 48'h1234_5678_9abc;  dir_ok[11] = 1'b1;
    // skew the counts, then evict and fail on a full cache
    dir_addr[12] = 48'h5555_5555_5555;  dir_ok[12] = 1'b1;
    dir_addr[13] = '0;                  dir_ok[13] = 1'b1;
    dir_addr[14] = 48'h0000_0000_0002;  dir_ok[14] = 1'b1;
    dir_addr[15] = 48'h7fff_ffff_ffff;  dir_ok[15] = 1'b0;
    dir_addr[16] = 48'h7fff_ffff_ffff;  dir_ok[16] = 1'b1;
    dir_addr[17] = 48'h0000_0000_0001;  dir_ok[17] = 1'b1;
    // hit with fill_ok low: flag is ignored; then a miss with fill_ok low fails
    dir_addr[18] = '1;                  dir_ok[18] = 1'b0;
    dir_addr[19] = 48'h5555_5555_5554;  dir_ok[19] = 1'b0;
    for (int i = 0; i < 20; i++) offer_request(dir_addr[i], dir_ok[i]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) new_segment();
      if (i == RANDOM_WORDS - QUIET_TAIL) quiet_tail = 1'b1;
      offer_request(pick_address(), $urandom_range(0, 99) < 85);
    end
    req_ch.valid <= 1'b0;
    @(posedge clk);

    // every result in, then a drain wait for stray words
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
